### rtl/ntc_temperature_frame_packer_macros.svh
// ----------------------------------------------------------------------------
// NTC frame packer assertion macros
// Shared helpers that keep the concurrent checks short and uniform.
// ----------------------------------------------------------------------------
`ifndef NTC_TEMPERATURE_FRAME_PACKER_MACROS_SVH
`define NTC_TEMPERATURE_FRAME_PACKER_MACROS_SVH

// Same-cycle implication, sampled on the block clock, quiet during reset.
`define NTCFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the block clock, quiet during reset.
`define NTCFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ntcfp_pkg.sv
// ----------------------------------------------------------------------------
// NTC frame packer package
// Field widths, reset values and arithmetic constants of the frame packer.
// ----------------------------------------------------------------------------
package ntcfp_pkg;

  // Field and register widths.
  localparam int RES_W     = 22;
  localparam int BETA_W    = 16;
  localparam int T0_W      = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 22;
  localparam int PAY_W     = 64;
  localparam int TEMP_W    = 12;
  localparam int PACK_W    = 60;
  localparam int CNT_W     = 3;

  // Default number of samples in one run.
  localparam int NUM_SENSORS_DEF = 5;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BETA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_R0   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_T0   = 2'd2;

  // Register reset values.
  localparam logic [BETA_W-1:0] BETA_RST = 16'd3984;
  localparam logic [RES_W-1:0]  R0_RST   = 22'd10000;
  localparam logic [T0_W-1:0]   T0_RST   = 16'd29815;

  // Arithmetic constants.
  localparam logic [31:0]       LN2_Q32   = 32'd2977044472;
  localparam logic [38:0]       ZERO_C_H  = 39'd27315;
  localparam logic [38:0]       SAT_X     = 39'd40950;   // x/10 reaches 4095 here
  localparam logic [15:0]       RECIP_10  = 16'd52429;   // 2^19/10, rounded up
  localparam logic [TEMP_W-1:0] TEMP_MAX  = 12'hFFF;

  // Frame kinds.
  localparam logic FRAME_TEMP = 1'b0;
  localparam logic FRAME_STAT = 1'b1;

endpackage

### rtl/ntc_temperature_frame_packer.sv
// ----------------------------------------------------------------------------
// NTC temperature frame packer
// Beta-equation thermistor conversion with temperature and statistics frames.
// ----------------------------------------------------------------------------
// Each item is a thermistor resistance, converted to tenths of a degree
// Celsius (clamped to 0..4095) and packed into a 60-bit frame. After
// NUM_SENSORS items the block emits the temperature frame and then a
// statistics frame (max, min, max-min). One item is worked on at a time.
// Between one accepted item and the next the block runs bit-serial
// normalization, 16 squaring steps of the logarithm, the subtraction, ln 2
// product and rounding of ln(R/R0), two 39-step restoring divisions with
// one quotient bit per cycle, the denominator check, the scaling, the divide
// by ten, the frame update and the idle state. A result that saturates skips
// the divide by ten, a denominator that is not positive skips the second
// division and the scaling, and a zero resistance goes straight to the frame
// update. The frames wait in a two-entry output buffer, so the next item is
// accepted while they are still being taken; a run that ends while the buffer
// is still occupied holds its last item until the buffer is empty.
module ntc_temperature_frame_packer #(
  parameter int NUM_SENSORS = ntcfp_pkg::NUM_SENSORS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ntcfp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ntcfp_pkg::CFG_DAT_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [ntcfp_pkg::RES_W-1:0]       resistance_ohms_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              frame_kind_o,
  output logic [ntcfp_pkg::PAY_W-1:0]       payload_o,
  output logic                              last_frame_o
);
  import ntcfp_pkg::*;

  `include "ntc_temperature_frame_packer_macros.svh"

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_NORM  = 12'b000000000010,
    S_LOG   = 12'b000000000100,
    S_LNSUB = 12'b000000001000,
    S_LNMUL = 12'b000000010000,
    S_LNADD = 12'b000000100000,
    S_DIV1  = 12'b000001000000,
    S_DEN   = 12'b000010000000,
    S_DIV2  = 12'b000100000000,
    S_SCALE = 12'b001000000000,
    S_RECIP = 12'b010000000000,
    S_FIN   = 12'b100000000000
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [BETA_W-1:0] beta_q;
  logic [RES_W-1:0]  r0_q;
  logic [T0_W-1:0]   t0_q;

  // Datapath registers.
  logic [RES_W-1:0]  na_q, nb_q;
  logic [4:0]        sa_q, sb_q;
  logic [30:0]       ma_q, mb_q;
  logic [15:0]       fa_q, fb_q;
  logic [5:0]        cnt_q;
  logic [20:0]       mag_q;
  logic              neg_q;
  logic [52:0]       prod_q;
  logic [20:0]       lnmag_q;
  logic [38:0]       num_q;
  logic [38:0]       quo_q;
  logic [39:0]       rem_q;
  logic [39:0]       dv_q;
  logic [31:0]       rp_q;
  logic [TEMP_W-1:0] t_q;

  // Run state.
  logic [CNT_W-1:0]  count_q;
  logic [PACK_W-1:0] packed_q;
  logic [TEMP_W-1:0] min_q, max_q;

  // Output buffer: current frame and a pending statistics frame.
  logic              out_valid_q, out_kind_q, pend_valid_q;
  logic [PAY_W-1:0]  out_payload_q, pend_payload_q;

  // Handshakes.
  logic in_fire, out_fire;
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_q && out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign frame_kind_o = out_kind_q;
  assign last_frame_o = out_kind_q;
  assign payload_o    = out_payload_q;

  // Zero reference values are taken as one.
  logic [RES_W-1:0] r0_eff;
  logic [T0_W-1:0]  t0_eff;
  assign r0_eff = (r0_q == '0) ? RES_W'(1) : r0_q;
  assign t0_eff = (t0_q == '0) ? T0_W'(1) : t0_q;

  // Squaring step of both logarithms.
  logic [61:0] sqa, sqb;
  logic [31:0] qa, qb;
  assign sqa = 62'(ma_q) * 62'(ma_q);
  assign sqb = 62'(mb_q) * 62'(mb_q);
  assign qa  = sqa[61:30];
  assign qb  = sqb[61:30];

  // Difference of the two Q5.16 logarithms.
  logic [21:0] la, lb, dl;
  assign la = {1'b0, 5'd21 - sa_q, fa_q};
  assign lb = {1'b0, 5'd21 - sb_q, fb_q};
  assign dl = la - lb;

  // Numerator B * 100 * 2^16.
  logic [22:0] b100;
  logic [38:0] num_w;
  assign b100  = 23'(beta_q) * 23'd100;
  assign num_w = {b100, 16'b0};

  // Rounded magnitude of ln(R/R0).
  logic [52:0] ln_sum;
  assign ln_sum = prod_q + 53'(64'd2147483648);

  // Restoring division step.
  logic [40:0] trial;
  logic        qbit;
  assign trial = {rem_q, quo_q[38]};
  assign qbit  = (trial >= {1'b0, dv_q});

  // Denominator B/T0 + ln(R/R0).
  logic [40:0] den;
  assign den = neg_q ? ({2'b0, quo_q} - {20'b0, lnmag_q})
                     : ({2'b0, quo_q} + {20'b0, lnmag_q});

  // Temperature above zero Celsius in hundredths.
  logic [38:0] xh;
  assign xh = quo_q - ZERO_C_H;

  // Run accumulation of the finished sample.
  logic [CNT_W-1:0]  count_d;
  logic [PACK_W-1:0] packed_d;
  logic [TEMP_W-1:0] min_d, max_d, diff;
  logic              emit;
  always_comb begin
    count_d  = count_q + CNT_W'(1);
    packed_d = packed_q;
    case (count_q)
      3'd0:    packed_d[11:0]  = packed_q[11:0]  | t_q;
      3'd1:    packed_d[23:12] = packed_q[23:12] | t_q;
      3'd2:    packed_d[35:24] = packed_q[35:24] | t_q;
      3'd3:    packed_d[47:36] = packed_q[47:36] | t_q;
      default: packed_d[59:48] = packed_q[59:48] | t_q;
    endcase
    if (count_q == '0) begin
      min_d = t_q;
      max_d = t_q;
    end else begin
      min_d = (t_q < min_q) ? t_q : min_q;
      max_d = (t_q > max_q) ? t_q : max_q;
    end
    diff = max_d - min_d;
    emit = (count_d == CNT_W'(NUM_SENSORS));
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q <= BETA_RST;
      r0_q   <= R0_RST;
      t0_q   <= T0_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BETA: beta_q <= cfg_data_i[BETA_W-1:0];
        REG_R0:   r0_q   <= cfg_data_i;
        REG_T0:   t0_q   <= cfg_data_i[T0_W-1:0];
        default:  ;
      endcase
    end
  end

  // Sequencer and run state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      packed_q     <= '0;
      min_q        <= '0;
      max_q        <= '0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= FRAME_TEMP;
      pend_valid_q <= 1'b0;
    end else begin
      // Output buffer drains in order.
      if (out_fire) begin
        if (pend_valid_q) begin
          out_kind_q   <= FRAME_STAT;
          pend_valid_q <= 1'b0;
        end else begin
          out_valid_q <= 1'b0;
        end
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            state_q <= (resistance_ohms_i == '0) ? S_FIN : S_NORM;
          end
        end
        S_NORM: begin
          if (na_q[RES_W-1] && nb_q[RES_W-1]) begin
            state_q <= S_LOG;
          end
        end
        S_LOG: begin
          if (cnt_q == '0) begin
            state_q <= S_LNSUB;
          end
        end
        S_LNSUB: state_q <= S_LNMUL;
        S_LNMUL: state_q <= S_LNADD;
        S_LNADD: state_q <= S_DIV1;
        S_DIV1: begin
          if (cnt_q == '0) begin
            state_q <= S_DEN;
          end
        end
        S_DEN: begin
          state_q <= (!den[40] && den != '0) ? S_DIV2 : S_FIN;
        end
        S_DIV2: begin
          if (cnt_q == '0) begin
            state_q <= S_SCALE;
          end
        end
        S_SCALE: begin
          state_q <= (quo_q < ZERO_C_H || xh >= SAT_X) ? S_FIN : S_RECIP;
        end
        S_RECIP: state_q <= S_FIN;
        S_FIN: begin
          if (!emit) begin
            count_q  <= count_d;
            packed_q <= packed_d;
            min_q    <= min_d;
            max_q    <= max_d;
            state_q  <= S_IDLE;
          end else if (!out_valid_q && !pend_valid_q) begin
            count_q      <= '0;
            packed_q     <= '0;
            min_q        <= '0;
            max_q        <= '0;
            out_valid_q  <= 1'b1;
            out_kind_q   <= FRAME_TEMP;
            pend_valid_q <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        na_q <= resistance_ohms_i;
        nb_q <= r0_eff;
        sa_q <= '0;
        sb_q <= '0;
        t_q  <= TEMP_MAX;
      end
      S_NORM: begin
        // Shift each operand left until its top bit is set.
        if (!na_q[RES_W-1]) begin
          na_q <= {na_q[RES_W-2:0], 1'b0};
          sa_q <= sa_q + 5'd1;
        end
        if (!nb_q[RES_W-1]) begin
          nb_q <= {nb_q[RES_W-2:0], 1'b0};
          sb_q <= sb_q + 5'd1;
        end
        ma_q  <= {na_q, 9'b0};
        mb_q  <= {nb_q, 9'b0};
        cnt_q <= 6'd15;
      end
      S_LOG: begin
        // One fraction bit of each logarithm per square.
        ma_q  <= qa[31] ? qa[31:1] : qa[30:0];
        mb_q  <= qb[31] ? qb[31:1] : qb[30:0];
        fa_q  <= {fa_q[14:0], qa[31]};
        fb_q  <= {fb_q[14:0], qb[31]};
        cnt_q <= cnt_q - 6'd1;
      end
      S_LNSUB: begin
        neg_q <= dl[21];
        mag_q <= dl[21] ? 21'(-dl) : dl[20:0];
      end
      S_LNMUL: begin
        prod_q <= 53'(mag_q) * 53'(LN2_Q32);
      end
      S_LNADD: begin
        lnmag_q <= ln_sum[52:32];
        num_q   <= num_w;
        quo_q   <= num_w;
        rem_q   <= '0;
        dv_q    <= 40'(t0_eff);
        cnt_q   <= 6'd38;
      end
      S_DIV1, S_DIV2: begin
        rem_q <= qbit ? 40'(trial - {1'b0, dv_q}) : trial[39:0];
        quo_q <= {quo_q[37:0], qbit};
        cnt_q <= cnt_q - 6'd1;
      end
      S_DEN: begin
        quo_q <= num_q;
        rem_q <= '0;
        dv_q  <= den[39:0];
        cnt_q <= 6'd38;
      end
      S_SCALE: begin
        if (quo_q < ZERO_C_H) begin
          t_q <= '0;
        end
        rp_q <= 32'(xh[15:0]) * 32'(RECIP_10);
      end
      S_RECIP: begin
        t_q <= rp_q[30:19];
      end
      S_FIN: begin
        if (emit && !out_valid_q && !pend_valid_q) begin
          out_payload_q  <= {4'b0, packed_d};
          pend_payload_q <= {28'b0, diff, min_d, max_d};
        end
      end
      default: ;
    endcase
    if (out_fire && pend_valid_q) begin
      out_payload_q <= pend_payload_q;
    end
  end

  // Shorthand for the checks below.
  logic load_now, both_loaded, stat_on_port, stat_ordered;
  assign load_now     = (state_q == S_FIN) && emit && !out_valid_q && !pend_valid_q;
  assign both_loaded  = out_valid_q && pend_valid_q && (out_kind_q == FRAME_TEMP);
  assign stat_on_port = out_valid_q && (out_kind_q == FRAME_STAT);
  assign stat_ordered = (out_payload_q[11:0] >= out_payload_q[23:12]);

  // A pending statistics frame always sits behind a frame on the port.
  `NTCFP_ASSERT_NOW(a_pend_behind_out, pend_valid_q, out_valid_q, "pending frame without output")
  // A finished run loads both frames at once.
  `NTCFP_ASSERT_NEXT(a_emit_loads, load_now, both_loaded, "frames not loaded")
  // The statistics maximum is never below the minimum.
  `NTCFP_ASSERT_NOW(a_stat_order, stat_on_port, stat_ordered, "statistics out of order")

endmodule
